### hw/rtl/sat_pkg.sv
// Package with constants, types and control structures of the SAT collision block.
package sat_pkg;

   localparam int MAX_VERTS = 8;
   localparam int IDX_W     = $clog2(MAX_VERTS);
   localparam int CNT_W     = IDX_W + 1;
   localparam int AX_W      = CNT_W + 1;
   localparam int PT_W      = 24;
   localparam int NRM_W     = 16;
   localparam int PROD_W    = PT_W + NRM_W;
   localparam int PROJ_W    = PROD_W + 1;
   localparam int OV_W      = PROJ_W + 1;
   localparam int HALF_W    = (OV_W + 1) / 2;
   localparam int SCL_W     = NRM_W + OV_W;
   localparam int OUT_W     = 32;
   localparam int RND_SHIFT = 28;

   localparam logic [1:0] STEP_LAST = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_AXIS,
      ST_MUL,
      ST_ACC,
      ST_EVAL1,
      ST_EVAL2,
      ST_EVAL3,
      ST_EVAL4,
      ST_SCALE,
      ST_ROUND,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic              load;
      logic              start;
      logic              miss;
      logic              axis_load;
      logic [AX_W-1:0]   axis;
      logic              mul;
      logic              poly;
      logic [IDX_W-1:0]  point;
      logic              acc;
      logic              eval1;
      logic              eval2;
      logic              eval3;
      logic              eval4;
      logic              scale;
      logic [1:0]        scale_step;
      logic              round;
      logic              rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0]  first_count;
      logic [CNT_W-1:0]  second_count;
      logic              separated;
   } dp_status_type;

endpackage

### hw/rtl/sat_datapath.sv
// Datapath with vertex stores, projection, overlap evaluation and push scaling.
module sat_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_command,
   input  logic signed [sat_pkg::PT_W-1:0]  req_point_x,
   input  logic signed [sat_pkg::PT_W-1:0]  req_point_y,
   input  logic signed [sat_pkg::NRM_W-1:0] req_normal_x,
   input  logic signed [sat_pkg::NRM_W-1:0] req_normal_y,
   input  logic                          req_last_vertex,
   input  sat_pkg::dp_cmd_type           cmd,
   output sat_pkg::dp_status_type        status,
   output logic                          rsp_hit,
   output logic signed [sat_pkg::OUT_W-1:0] rsp_push_x,
   output logic signed [sat_pkg::OUT_W-1:0] rsp_push_y
);
   import sat_pkg::*;

   logic signed [PT_W-1:0]  first_px_ff  [MAX_VERTS];
   logic signed [PT_W-1:0]  first_py_ff  [MAX_VERTS];
   logic signed [NRM_W-1:0] first_nx_ff  [MAX_VERTS];
   logic signed [NRM_W-1:0] first_ny_ff  [MAX_VERTS];
   logic signed [PT_W-1:0]  second_px_ff [MAX_VERTS];
   logic signed [PT_W-1:0]  second_py_ff [MAX_VERTS];
   logic signed [NRM_W-1:0] second_nx_ff [MAX_VERTS];
   logic signed [NRM_W-1:0] second_ny_ff [MAX_VERTS];

   logic [CNT_W-1:0] first_count_ff, second_count_ff;
   logic             first_closed_ff;
   logic [CNT_W-1:0] load_idx_in;

   logic signed [NRM_W-1:0]  ax_x_ff, ax_y_ff;
   logic signed [PROD_W-1:0] prod_x_ff, prod_y_ff;
   logic                     mul_poly_ff, mul_first_ff;
   logic signed [PROJ_W-1:0] alo_ff, ahi_ff, blo_ff, bhi_ff;
   logic signed [PROJ_W-1:0] mnhi_ff, mxlo_ff;
   logic signed [OV_W-1:0]   g0_ff, g1_ff, base_ff, gmin_ff, ov_ff, best_ff;
   logic                     sep_ff, contain_ff, have_ff, hit_ff;
   logic signed [NRM_W-1:0]  best_nx_ff, best_ny_ff;
   logic signed [SCL_W-1:0]  scl_x_ff, scl_y_ff;
   logic signed [OUT_W-1:0]  push_x_ff, push_y_ff;
   logic                     rsp_hit_ff;
   logic signed [OUT_W-1:0]  rsp_push_x_ff, rsp_push_y_ff;

   logic [AX_W-1:0]          axis_off_in;
   logic signed [PT_W-1:0]   sel_px_in, sel_py_in;
   logic signed [PROJ_W-1:0] proj_in;
   logic signed [OV_W-1:0]   ov_x_in, ov_y_in;
   logic signed [NRM_W-1:0]  scl_n_in;
   logic signed [NRM_W+HALF_W:0] part_lo_in, part_hi_in;
   logic signed [SCL_W-1:0]  scl_cur_in, scl_part_in;
   logic signed [SCL_W-1:0]  rnd_x_in, rnd_y_in;

   assign status.first_count  = first_count_ff;
   assign status.second_count = second_count_ff;
   assign status.separated    = sep_ff;

   assign load_idx_in = first_closed_ff ? '0 : first_count_ff;
   assign axis_off_in = cmd.axis - AX_W'(first_count_ff);

   always_comb begin
      sel_px_in = cmd.poly ? second_px_ff[cmd.point] : first_px_ff[cmd.point];
      sel_py_in = cmd.poly ? second_py_ff[cmd.point] : first_py_ff[cmd.point];
      proj_in   = PROJ_W'(prod_x_ff) + PROJ_W'(prod_y_ff);
      ov_x_in   = OV_W'(alo_ff) - OV_W'(blo_ff);
      ov_y_in   = OV_W'(ahi_ff) - OV_W'(bhi_ff);
      scl_n_in  = cmd.scale_step[1] ? best_ny_ff : best_nx_ff;
      scl_cur_in = cmd.scale_step[1] ? scl_y_ff : scl_x_ff;
      part_lo_in = scl_n_in * $signed({1'b0, best_ff[HALF_W-1:0]});
      part_hi_in = scl_n_in * $signed(best_ff[OV_W-1:HALF_W]);
      if (!cmd.scale_step[0]) begin
         scl_part_in = SCL_W'(part_lo_in);
      end else begin
         scl_part_in = scl_cur_in + (SCL_W'(part_hi_in) <<< HALF_W);
      end
      rnd_x_in = scl_x_ff + (SCL_W'(1) <<< (RND_SHIFT - 1));
      rnd_y_in = scl_y_ff + (SCL_W'(1) <<< (RND_SHIFT - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_count_ff  <= '0;
         second_count_ff <= '0;
         first_closed_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         first_count_ff  <= '0;
         second_count_ff <= '0;
         first_closed_ff <= 1'b0;
      end else if (cmd.load) begin
         if (!req_command) begin
            first_closed_ff <= req_last_vertex;
            if (load_idx_in < CNT_W'(MAX_VERTS)) begin
               first_count_ff <= load_idx_in + 1'b1;
            end else begin
               first_count_ff <= load_idx_in;
            end
         end else if (second_count_ff < CNT_W'(MAX_VERTS)) begin
            second_count_ff <= second_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         if (!req_command) begin
            if (load_idx_in < CNT_W'(MAX_VERTS)) begin
               first_px_ff[load_idx_in[IDX_W-1:0]] <= req_point_x;
               first_py_ff[load_idx_in[IDX_W-1:0]] <= req_point_y;
               first_nx_ff[load_idx_in[IDX_W-1:0]] <= req_normal_x;
               first_ny_ff[load_idx_in[IDX_W-1:0]] <= req_normal_y;
            end
         end else if (second_count_ff < CNT_W'(MAX_VERTS)) begin
            second_px_ff[second_count_ff[IDX_W-1:0]] <= req_point_x;
            second_py_ff[second_count_ff[IDX_W-1:0]] <= req_point_y;
            second_nx_ff[second_count_ff[IDX_W-1:0]] <= req_normal_x;
            second_ny_ff[second_count_ff[IDX_W-1:0]] <= req_normal_y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         hit_ff  <= (first_count_ff != '0);
         have_ff <= 1'b0;
      end
      if (cmd.miss) begin
         hit_ff <= 1'b0;
      end
      if (cmd.axis_load) begin
         if (cmd.axis < AX_W'(first_count_ff)) begin
            ax_x_ff <= first_nx_ff[cmd.axis[IDX_W-1:0]];
            ax_y_ff <= first_ny_ff[cmd.axis[IDX_W-1:0]];
         end else begin
            ax_x_ff <= second_nx_ff[axis_off_in[IDX_W-1:0]];
            ax_y_ff <= second_ny_ff[axis_off_in[IDX_W-1:0]];
         end
      end
      if (cmd.mul) begin
         prod_x_ff    <= ax_x_ff * sel_px_in;
         prod_y_ff    <= ax_y_ff * sel_py_in;
         mul_poly_ff  <= cmd.poly;
         mul_first_ff <= (cmd.point == '0);
      end
      if (cmd.acc) begin
         if (!mul_poly_ff) begin
            if (mul_first_ff || proj_in < alo_ff) alo_ff <= proj_in;
            if (mul_first_ff || proj_in > ahi_ff) ahi_ff <= proj_in;
         end else begin
            if (mul_first_ff || proj_in < blo_ff) blo_ff <= proj_in;
            if (mul_first_ff || proj_in > bhi_ff) bhi_ff <= proj_in;
         end
      end
      if (cmd.eval1) begin
         sep_ff     <= (alo_ff > bhi_ff) || (blo_ff > ahi_ff);
         mnhi_ff    <= (ahi_ff < bhi_ff) ? ahi_ff : bhi_ff;
         mxlo_ff    <= (alo_ff > blo_ff) ? alo_ff : blo_ff;
         contain_ff <= ((alo_ff > blo_ff) && (ahi_ff < bhi_ff)) ||
                       ((blo_ff > alo_ff) && (bhi_ff < ahi_ff));
         g0_ff      <= (ov_x_in < 0) ? -ov_x_in : ov_x_in;
         g1_ff      <= (ov_y_in < 0) ? -ov_y_in : ov_y_in;
      end
      if (cmd.eval2) begin
         base_ff <= OV_W'(mnhi_ff) - OV_W'(mxlo_ff);
         gmin_ff <= contain_ff ? ((g0_ff < g1_ff) ? g0_ff : g1_ff) : '0;
      end
      if (cmd.eval3) begin
         ov_ff <= base_ff + gmin_ff;
      end
      if (cmd.eval4) begin
         if (!have_ff || ov_ff < best_ff) begin
            have_ff    <= 1'b1;
            best_ff    <= ov_ff;
            best_nx_ff <= ax_x_ff;
            best_ny_ff <= ax_y_ff;
         end
      end
      if (cmd.scale) begin
         if (cmd.scale_step[1]) begin
            scl_y_ff <= scl_part_in;
         end else begin
            scl_x_ff <= scl_part_in;
         end
      end
      if (cmd.round) begin
         push_x_ff <= OUT_W'(rnd_x_in >>> RND_SHIFT);
         push_y_ff <= OUT_W'(rnd_y_in >>> RND_SHIFT);
      end
      if (cmd.rsp_load) begin
         rsp_hit_ff    <= hit_ff;
         rsp_push_x_ff <= hit_ff ? push_x_ff : '0;
         rsp_push_y_ff <= hit_ff ? push_y_ff : '0;
      end
   end

   assign rsp_hit    = rsp_hit_ff;
   assign rsp_push_x = rsp_push_x_ff;
   assign rsp_push_y = rsp_push_y_ff;

endmodule

### hw/rtl/sat_controller.sv
// Controller state machine sequencing loads, axis sweeps, scaling and the result handshake.
module sat_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_command,
   input  logic                    req_last_vertex,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  sat_pkg::dp_status_type  status,
   output sat_pkg::dp_cmd_type     cmd
);
   import sat_pkg::*;

   state_type        state_ff, state_in;
   logic [AX_W-1:0]  axis_ff, axis_in;
   logic             poly_ff, poly_in;
   logic [IDX_W-1:0] point_ff, point_in;
   logic [1:0]       step_ff, step_in;
   logic             rsp_valid_ff;
   logic [AX_W-1:0]  total_in;
   logic [CNT_W-1:0] poly_count_in;

   assign total_in      = AX_W'(status.first_count) + AX_W'(status.second_count);
   assign poly_count_in = poly_ff ? status.second_count : status.first_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= '0;
         poly_ff      <= 1'b0;
         point_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         poly_ff  <= poly_in;
         point_ff <= point_in;
         step_ff  <= step_in;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      axis_in        = axis_ff;
      poly_in        = poly_ff;
      point_in       = point_ff;
      step_in        = step_ff;
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.axis       = axis_ff;
      cmd.poly       = poly_ff;
      cmd.point      = point_ff;
      cmd.scale_step = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_command && req_last_vertex) begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            cmd.start = 1'b1;
            axis_in   = '0;
            if (status.first_count == '0) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_AXIS;
            end
         end
         ST_AXIS: begin
            cmd.axis_load = 1'b1;
            poly_in       = 1'b0;
            point_in      = '0;
            state_in      = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc = 1'b1;
            if (CNT_W'(point_ff) + 1'b1 < poly_count_in) begin
               point_in = point_ff + 1'b1;
               state_in = ST_MUL;
            end else if (!poly_ff) begin
               poly_in  = 1'b1;
               point_in = '0;
               state_in = ST_MUL;
            end else begin
               state_in = ST_EVAL1;
            end
         end
         ST_EVAL1: begin
            cmd.eval1 = 1'b1;
            state_in  = ST_EVAL2;
         end
         ST_EVAL2: begin
            if (status.separated) begin
               cmd.miss = 1'b1;
               state_in = ST_FINISH;
            end else begin
               cmd.eval2 = 1'b1;
               state_in  = ST_EVAL3;
            end
         end
         ST_EVAL3: begin
            cmd.eval3 = 1'b1;
            state_in  = ST_EVAL4;
         end
         ST_EVAL4: begin
            cmd.eval4 = 1'b1;
            if (axis_ff + 1'b1 < total_in) begin
               axis_in  = axis_ff + 1'b1;
               state_in = ST_AXIS;
            end else begin
               step_in  = '0;
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            step_in   = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   a_mul_has_points: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (status.second_count != '0 && status.first_count != '0))
      else $error("projection started with an empty polygon");

   a_axis_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_AXIS) |-> (axis_ff < total_in))
      else $error("axis index beyond the loaded normals");

   a_acc_after_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC) |-> ($past(state_ff) == ST_MUL))
      else $error("accumulate without a product");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_valid_ff)
      else $error("result loaded but not presented");

endmodule

### hw/rtl/sat_polygon_collision_mtv.sv
// Top level of the two-polygon separating-axis collision block with translation vector.
// Each vertex request is accepted in the idle state.
// The closing vertex of the second polygon starts a sweep of up to (F+S) axes, each projecting
// both polygons through one shared projection multiplier pair; the sweep stops at the first
// separating axis, and a full sweep is followed by scaling, rounding and the response load.
// Synchronous active-high reset clears the vertex counts, the sequencer and the response valid flag.
module sat_polygon_collision_mtv (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_command,
   input  logic signed [sat_pkg::PT_W-1:0]   req_point_x,
   input  logic signed [sat_pkg::PT_W-1:0]   req_point_y,
   input  logic signed [sat_pkg::NRM_W-1:0]  req_normal_x,
   input  logic signed [sat_pkg::NRM_W-1:0]  req_normal_y,
   input  logic                              req_last_vertex,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_hit,
   output logic signed [sat_pkg::OUT_W-1:0]  rsp_push_x,
   output logic signed [sat_pkg::OUT_W-1:0]  rsp_push_y
);
   import sat_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   sat_controller u_controller (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_command     (req_command),
      .req_last_vertex (req_last_vertex),
      .req_ready       (req_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .status          (status),
      .cmd             (cmd)
   );

   sat_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_command     (req_command),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_normal_x    (req_normal_x),
      .req_normal_y    (req_normal_y),
      .req_last_vertex (req_last_vertex),
      .cmd             (cmd),
      .status          (status),
      .rsp_hit         (rsp_hit),
      .rsp_push_x      (rsp_push_x),
      .rsp_push_y      (rsp_push_y)
   );

endmodule
